FILE: hdl/srhm_pkg.sv
// Shared types, constants and codes for the sample rate health monitor.
package srhm_pkg;

   localparam int GAP_W      = 20;
   localparam int MIN_GAPS   = 4;
   localparam int REQ_DATA_W = 64;
   localparam int RSP_DATA_W = 128;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;
   localparam int MUL_W      = 32;
   localparam int PROD_W     = 2 * MUL_W;

   localparam logic [GAP_W-1:0] GAP_MAX  = 20'hFFFFF;
   localparam logic [19:0]      US_PER_S = 20'd1000000;

   localparam logic [CSR_IDX_W-1:0] CSR_DEGRADED_RATE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NOMINAL_RATE  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXCLUSIVE_CV  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CONTESTED_CV  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_WARMUP        = 3'd4;

   localparam logic [19:0] DEGRADED_RATE_RESET = 20'd500;
   localparam logic [19:0] NOMINAL_RATE_RESET  = 20'd900;
   localparam logic [15:0] EXCLUSIVE_CV_RESET  = 16'd3277;
   localparam logic [15:0] CONTESTED_CV_RESET  = 16'd19661;
   localparam logic [31:0] WARMUP_RESET        = 32'd1000;

   localparam logic [1:0] RATE_DISCONNECTED = 2'd0;
   localparam logic [1:0] RATE_DEGRADED     = 2'd1;
   localparam logic [1:0] RATE_NOMINAL      = 2'd2;

   localparam logic [1:0] HOST_UNKNOWN   = 2'd0;
   localparam logic [1:0] HOST_EXCLUSIVE = 2'd1;
   localparam logic [1:0] HOST_CONTESTED = 2'd2;

   typedef struct packed {
      logic [19:0] degraded_rate_hz;
      logic [19:0] nominal_rate_hz;
      logic [15:0] exclusive_cv_q16;
      logic [15:0] contested_cv_q16;
      logic [31:0] warmup_needed;
   } cfg_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_RING,
      ST_OLDSQ,
      ST_GAPSQ,
      ST_QADD,
      ST_SSQ,
      ST_NQLO,
      ST_NQHI,
      ST_NQACC,
      ST_DEG,
      ST_NOM,
      ST_EXLO,
      ST_EXHI,
      ST_EXCMP,
      ST_CTLO,
      ST_CTHI,
      ST_CTCMP,
      ST_FIN
   } state_type;

   typedef enum logic [3:0] {
      MUL_OLD_SQ,
      MUL_GAP_SQ,
      MUL_SUM_SQ,
      MUL_NQ_LO,
      MUL_NQ_HI,
      MUL_DEG,
      MUL_NOM,
      MUL_EXC_SQ,
      MUL_CON_SQ,
      MUL_C2_SLO,
      MUL_C2_SHI
   } mul_sel_type;

   typedef struct packed {
      logic        take;
      logic        ring_rw;
      logic        sum_upd;
      logic        qsum_sub;
      logic        qsum_add;
      mul_sel_type mul_sel;
      logic        s2_ld;
      logic        nq_ld;
      logic        nq_acc;
      logic        spread_ld;
      logic        deg_ld;
      logic        nom_ld;
      logic        c2_ld;
      logic        rlo_ld;
      logic        excl_ld;
      logic        cont_ld;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic prev_zero;
      logic enough;
   } status_type;

endpackage

FILE: hdl/srhm_csr.sv
// Configuration registers of the sample rate health monitor.
module srhm_csr import srhm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_DEGRADED_RATE: cfg_in.degraded_rate_hz = csr_wdata[19:0];
            CSR_NOMINAL_RATE:  cfg_in.nominal_rate_hz  = csr_wdata[19:0];
            CSR_EXCLUSIVE_CV:  cfg_in.exclusive_cv_q16 = csr_wdata[15:0];
            CSR_CONTESTED_CV:  cfg_in.contested_cv_q16 = csr_wdata[15:0];
            CSR_WARMUP:        cfg_in.warmup_needed    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.degraded_rate_hz <= DEGRADED_RATE_RESET;
         cfg_ff.nominal_rate_hz  <= NOMINAL_RATE_RESET;
         cfg_ff.exclusive_cv_q16 <= EXCLUSIVE_CV_RESET;
         cfg_ff.contested_cv_q16 <= CONTESTED_CV_RESET;
         cfg_ff.warmup_needed    <= WARMUP_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: hdl/srhm_ctrl.sv
// Sequencing controller of the sample rate health monitor.
module srhm_ctrl import srhm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      state_in   = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.take = 1'b1;
               if (!status.prev_zero) begin
                  state_in = ST_RING;
               end
            end
         end
         ST_RING: begin
            cmd.ring_rw = 1'b1;
            state_in    = ST_OLDSQ;
         end
         ST_OLDSQ: begin
            cmd.mul_sel = MUL_OLD_SQ;
            cmd.sum_upd = 1'b1;
            state_in    = ST_GAPSQ;
         end
         ST_GAPSQ: begin
            cmd.mul_sel  = MUL_GAP_SQ;
            cmd.qsum_sub = 1'b1;
            state_in     = ST_QADD;
         end
         ST_QADD: begin
            cmd.qsum_add = 1'b1;
            state_in     = ST_SSQ;
         end
         ST_SSQ: begin
            cmd.mul_sel = MUL_SUM_SQ;
            state_in    = status.enough ? ST_NQLO : ST_IDLE;
         end
         ST_NQLO: begin
            cmd.s2_ld   = 1'b1;
            cmd.mul_sel = MUL_NQ_LO;
            state_in    = ST_NQHI;
         end
         ST_NQHI: begin
            cmd.nq_ld   = 1'b1;
            cmd.mul_sel = MUL_NQ_HI;
            state_in    = ST_NQACC;
         end
         ST_NQACC: begin
            cmd.nq_acc  = 1'b1;
            cmd.mul_sel = MUL_DEG;
            state_in    = ST_DEG;
         end
         ST_DEG: begin
            cmd.spread_ld = 1'b1;
            cmd.deg_ld    = 1'b1;
            cmd.mul_sel   = MUL_NOM;
            state_in      = ST_NOM;
         end
         ST_NOM: begin
            cmd.nom_ld  = 1'b1;
            cmd.mul_sel = MUL_EXC_SQ;
            state_in    = ST_EXLO;
         end
         ST_EXLO: begin
            cmd.c2_ld   = 1'b1;
            cmd.mul_sel = MUL_C2_SLO;
            state_in    = ST_EXHI;
         end
         ST_EXHI: begin
            cmd.rlo_ld  = 1'b1;
            cmd.mul_sel = MUL_C2_SHI;
            state_in    = ST_EXCMP;
         end
         ST_EXCMP: begin
            cmd.excl_ld = 1'b1;
            cmd.mul_sel = MUL_CON_SQ;
            state_in    = ST_CTLO;
         end
         ST_CTLO: begin
            cmd.c2_ld   = 1'b1;
            cmd.mul_sel = MUL_C2_SLO;
            state_in    = ST_CTHI;
         end
         ST_CTHI: begin
            cmd.rlo_ld  = 1'b1;
            cmd.mul_sel = MUL_C2_SHI;
            state_in    = ST_CTCMP;
         end
         ST_CTCMP: begin
            cmd.cont_ld = 1'b1;
            state_in    = ST_FIN;
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = cmd.finish | (rsp_valid_ff & ~rsp_tready);
   assign rsp_tvalid   = rsp_valid_ff;

   a_finish_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register loaded while an earlier result was still pending");

   a_first_sample_idle: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && status.prev_zero) |=> state_ff == ST_IDLE)
      else $error("first sample after a zero time did not return to idle");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(state_ff) == ST_FIN)
      else $error("result became valid outside the finish step");

endmodule

FILE: hdl/srhm_datapath.sv
// Datapath of the sample rate health monitor: gap ring, running sums and shared multiplier.
module srhm_datapath import srhm_pkg::*; #(
   parameter int WINDOW_DEPTH = 60
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  cfg_type               cfg,
   input  cmd_type               cmd,
   output status_type            status,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   localparam int IDX_W  = $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W  = GAP_W + CNT_W;
   localparam int QSUM_W = 2 * GAP_W + CNT_W;
   localparam int S2_W   = 2 * SUM_W;
   localparam int NQ_W   = CNT_W + QSUM_W;
   localparam int CMP_W  = S2_W + MUL_W;
   localparam int RHS_W  = 20 + CNT_W;

   logic [GAP_W-1:0]      ring [WINDOW_DEPTH];

   logic [REQ_DATA_W-1:0] prev_ff;
   logic [GAP_W-1:0]      gap_ff;
   logic [GAP_W-1:0]      old_ff;
   logic [IDX_W-1:0]      widx_ff;
   logic                  full_ff;
   logic [CNT_W-1:0]      count_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [QSUM_W-1:0]     qsum_ff;
   logic [31:0]           run_ff;
   logic [PROD_W-1:0]     prod_ff;
   logic [S2_W-1:0]       s2_ff;
   logic [NQ_W-1:0]       nq_ff;
   logic [NQ_W-1:0]       spread_ff;
   logic                  deg_ff;
   logic                  nom_ff;
   logic [MUL_W-1:0]      c2_ff;
   logic [PROD_W-1:0]     rlo_ff;
   logic                  excl_ff;
   logic                  cont_ff;
   logic [RSP_DATA_W-1:0] rsp_ff;

   logic [REQ_DATA_W-1:0] diff;
   logic [GAP_W-1:0]      gap_in;
   logic [SUM_W-1:0]      sum_in;
   logic [QSUM_W-1:0]     qsum_in;
   logic                  idx_last;
   logic [IDX_W-1:0]      widx_in;
   logic [CNT_W-1:0]      count_in;
   logic [MUL_W-1:0]      mul_a;
   logic [MUL_W-1:0]      mul_b;
   logic [PROD_W-1:0]     prod_in;
   logic [NQ_W-1:0]       nq_in;
   logic [NQ_W-1:0]       spread_in;
   logic [RHS_W-1:0]      rate_rhs;
   logic                  sum_zero;
   logic                  rate_below;
   logic [CMP_W-1:0]      cmp_lhs;
   logic [CMP_W-1:0]      cmp_rhs;
   logic                  cv_below;
   logic                  nominal;
   logic [1:0]            rate_in;
   logic [1:0]            host_in;
   logic [31:0]           run_step;
   logic [31:0]           run_in;
   logic                  ready_in;
   logic [RSP_DATA_W-1:0] rsp_in;

   assign diff   = req_tdata - prev_ff;
   assign gap_in = (diff > REQ_DATA_W'(GAP_MAX)) ? GAP_MAX : diff[GAP_W-1:0];

   assign sum_in = sum_ff - (full_ff ? SUM_W'(old_ff) : SUM_W'(0)) + SUM_W'(gap_ff);

   always_comb begin
      if (cmd.qsum_sub) begin
         qsum_in = qsum_ff - (full_ff ? QSUM_W'(prod_ff[2*GAP_W-1:0]) : QSUM_W'(0));
      end else begin
         qsum_in = qsum_ff + QSUM_W'(prod_ff[2*GAP_W-1:0]);
      end
   end

   assign idx_last = (widx_ff == IDX_W'(WINDOW_DEPTH - 1));
   assign widx_in  = idx_last ? IDX_W'(0) : widx_ff + IDX_W'(1);
   assign count_in = (idx_last || full_ff) ? CNT_W'(WINDOW_DEPTH)
                                           : CNT_W'(widx_ff) + CNT_W'(1);

   always_comb begin
      unique case (cmd.mul_sel)
         MUL_OLD_SQ: begin
            mul_a = MUL_W'(old_ff);
            mul_b = MUL_W'(old_ff);
         end
         MUL_GAP_SQ: begin
            mul_a = MUL_W'(gap_ff);
            mul_b = MUL_W'(gap_ff);
         end
         MUL_SUM_SQ: begin
            mul_a = MUL_W'(sum_ff);
            mul_b = MUL_W'(sum_ff);
         end
         MUL_NQ_LO: begin
            mul_a = MUL_W'(count_ff);
            mul_b = qsum_ff[MUL_W-1:0];
         end
         MUL_NQ_HI: begin
            mul_a = MUL_W'(count_ff);
            mul_b = MUL_W'(qsum_ff[QSUM_W-1:MUL_W]);
         end
         MUL_DEG: begin
            mul_a = MUL_W'(cfg.degraded_rate_hz);
            mul_b = MUL_W'(sum_ff);
         end
         MUL_NOM: begin
            mul_a = MUL_W'(cfg.nominal_rate_hz);
            mul_b = MUL_W'(sum_ff);
         end
         MUL_EXC_SQ: begin
            mul_a = MUL_W'(cfg.exclusive_cv_q16);
            mul_b = MUL_W'(cfg.exclusive_cv_q16);
         end
         MUL_CON_SQ: begin
            mul_a = MUL_W'(cfg.contested_cv_q16);
            mul_b = MUL_W'(cfg.contested_cv_q16);
         end
         MUL_C2_SLO: begin
            mul_a = prod_ff[MUL_W-1:0];
            mul_b = s2_ff[MUL_W-1:0];
         end
         MUL_C2_SHI: begin
            mul_a = c2_ff;
            mul_b = MUL_W'(s2_ff[S2_W-1:MUL_W]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   assign nq_in     = nq_ff + {prod_ff[NQ_W-MUL_W-1:0], {MUL_W{1'b0}}};
   assign spread_in = (nq_ff >= s2_ff) ? nq_ff - s2_ff : '0;

   // With an all-zero sum the rate counts as zero Hz.
   assign rate_rhs   = RHS_W'(US_PER_S) * RHS_W'(count_ff);
   assign sum_zero   = (sum_ff == '0);
   assign rate_below = prod_ff > PROD_W'(rate_rhs);

   assign cmp_lhs  = {spread_ff, {MUL_W{1'b0}}};
   assign cmp_rhs  = {prod_ff[S2_W-1:0], {MUL_W{1'b0}}} + CMP_W'(rlo_ff);
   assign cv_below = cmp_lhs < cmp_rhs;

   assign nominal  = !deg_ff && !nom_ff;
   assign rate_in  = deg_ff ? RATE_DISCONNECTED : (nom_ff ? RATE_DEGRADED : RATE_NOMINAL);
   assign run_step = !nominal ? 32'd0 : ((run_ff == 32'hFFFF_FFFF) ? run_ff : run_ff + 32'd1);

   always_comb begin
      if (nominal && excl_ff) begin
         host_in = HOST_EXCLUSIVE;
         run_in  = run_step;
      end else if (cont_ff) begin
         host_in = HOST_CONTESTED;
         run_in  = 32'd0;
      end else begin
         host_in = HOST_UNKNOWN;
         run_in  = run_step;
      end
   end

   assign ready_in = nominal && (host_in != HOST_CONTESTED) && (run_in >= cfg.warmup_needed);

   assign rsp_in = {7'd0, 52'(spread_ff), 26'(sum_ff), 6'(count_ff),
                    run_in, ready_in, host_in, rate_in};

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         widx_ff  <= '0;
         full_ff  <= 1'b0;
         count_ff <= '0;
         sum_ff   <= '0;
         qsum_ff  <= '0;
         run_ff   <= '0;
      end else begin
         if (cmd.take) begin
            prev_ff <= req_tdata;
         end
         if (cmd.sum_upd) begin
            sum_ff <= sum_in;
         end
         if (cmd.qsum_sub || cmd.qsum_add) begin
            qsum_ff <= qsum_in;
         end
         if (cmd.qsum_add) begin
            widx_ff  <= widx_in;
            count_ff <= count_in;
            if (idx_last) begin
               full_ff <= 1'b1;
            end
         end
         if (cmd.finish) begin
            run_ff <= run_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (cmd.take) begin
         gap_ff <= gap_in;
      end
      if (cmd.s2_ld) begin
         s2_ff <= prod_ff[S2_W-1:0];
      end
      if (cmd.nq_ld) begin
         nq_ff <= NQ_W'(prod_ff);
      end
      if (cmd.nq_acc) begin
         nq_ff <= nq_in;
      end
      if (cmd.spread_ld) begin
         spread_ff <= spread_in;
      end
      if (cmd.deg_ld) begin
         deg_ff <= sum_zero ? (cfg.degraded_rate_hz != '0) : rate_below;
      end
      if (cmd.nom_ld) begin
         nom_ff <= sum_zero ? (cfg.nominal_rate_hz != '0) : rate_below;
      end
      if (cmd.c2_ld) begin
         c2_ff <= prod_ff[MUL_W-1:0];
      end
      if (cmd.rlo_ld) begin
         rlo_ff <= prod_ff;
      end
      if (cmd.excl_ld) begin
         excl_ff <= cv_below;
      end
      if (cmd.cont_ld) begin
         cont_ff <= !cv_below;
      end
      if (cmd.finish) begin
         rsp_ff <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ring_rw) begin
         old_ff        <= ring[widx_ff];
         ring[widx_ff] <= gap_ff;
      end
   end

   assign status.prev_zero = (prev_ff == '0);
   assign status.enough    = (count_ff >= CNT_W'(MIN_GAPS));
   assign rsp_tdata        = rsp_ff;

   a_index_in_window: assert property (@(posedge clock) disable iff (reset)
      widx_ff <= IDX_W'(WINDOW_DEPTH - 1))
      else $error("ring write index left the window");

   a_sum_only_on_update: assert property (@(posedge clock) disable iff (reset)
      !cmd.sum_upd |=> $stable(sum_ff))
      else $error("running sum changed outside its update step");

   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(WINDOW_DEPTH))
      else $error("gap count exceeded the window depth");

endmodule

FILE: hdl/sample_rate_health_monitor_unit.sv
// Top level of the sample rate health monitor.
//
// Each transaction on the req_ channel carries one 64-bit sample timestamp in
// microseconds. The gap to the previous timestamp goes into a ring of recent
// gaps, and once four or more gaps are held, each sample produces one
// transaction on the rsp_ channel with the rate class, host class, ready flag,
// nominal run, window count, gap sum and spread numerator.
// Items are handled one at a time by a sequencer around a single shared 32x32
// multiplier; a sample that yields a result passes the ring, sum, spread, rate
// and host steps, and its result is loaded in the final step. A sample that
// only records its time ends in the idle step, and one that only fills the
// ring returns to idle after the sum steps. Configuration writes through csr_
// take effect at once and should only be made while the block is idle.
// Reset clears the previous time, the ring pointer, the sums and the nominal
// run, and loads the default thresholds. While the receiver stalls, the
// result register holds its transaction; the next sample can still be taken
// and worked on, and its result waits in the final step until the register
// is free.
module sample_rate_health_monitor_unit import srhm_pkg::*; #(
   parameter int WINDOW_DEPTH = 60
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // sample_time_us [63:0]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // rate_state [1:0], host_class [3:2], ready_res [4], nominal_run [36:5],
   // window_count [42:37], interval_sum [68:43], spread_numerator [120:69]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type    cfg;
   cmd_type    cmd;
   status_type status;

   srhm_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   srhm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   srhm_datapath #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .cfg       (cfg),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata)
   );

endmodule

FILE: bench/health_report_checker.sv
// Predicts and checks the health reports of the sample rate health monitor from its channels.
module health_report_checker import srhm_pkg::*; #(
   parameter int WINDOW_DEPTH = 60
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    reports_pending,
   output int                    reports_checked
);

   typedef struct packed {
      logic [51:0] spread_numerator;
      logic [25:0] interval_sum;
      logic [5:0]  window_count;
      logic [31:0] nominal_run;
      logic        ready_res;
      logic [1:0]  host_class;
      logic [1:0]  rate_state;
   } health_report_type;

   localparam int REPORT_W = $bits(health_report_type);

   cfg_type           thresholds;
   logic [63:0]       last_stamp;
   logic [19:0]       gap_ring [WINDOW_DEPTH];
   int unsigned       ring_pos;
   bit                ring_wrapped;
   logic [63:0]       gap_total;
   logic [63:0]       gap_sq_total;
   logic [31:0]       nominal_streak;
   health_report_type report_queue [$];
   health_report_type got_report;
   health_report_type want_report;
   int                bad_count;
   int                checked_count;

   initial begin
      bad_count = 0;
      checked_count = 0;
   end

   function automatic int field_differs(string field, logic [63:0] want, logic [63:0] got);
      if (want === got) return 0;
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      return 1;
   endfunction

   task automatic predict_health(input logic [63:0] now_us);
      logic [63:0]       gap_us;
      logic [63:0]       n;
      logic [63:0]       s;
      logic [63:0]       s2;
      logic [63:0]       nq;
      logic [63:0]       spread;
      logic [19:0]       old_gap;
      logic [127:0]      spread_scaled;
      logic [127:0]      excl_bound;
      logic [127:0]      cont_bound;
      logic [1:0]        rate;
      logic [1:0]        host;
      bit                below_excl;
      bit                at_cont;
      health_report_type report;
      if (last_stamp == 64'd0) begin
         last_stamp = now_us;
         return;
      end
      gap_us = now_us - last_stamp;
      if (gap_us > 64'(GAP_MAX)) gap_us = 64'(GAP_MAX);
      last_stamp = now_us;

      if (ring_wrapped) begin
         old_gap = gap_ring[ring_pos];
         gap_total = gap_total - 64'(old_gap);
         gap_sq_total = gap_sq_total - 64'(old_gap) * 64'(old_gap);
      end
      gap_ring[ring_pos] = gap_us[19:0];
      gap_total = gap_total + gap_us;
      gap_sq_total = gap_sq_total + gap_us * gap_us;
      ring_pos++;
      if (ring_pos == WINDOW_DEPTH) begin
         ring_pos = 0;
         ring_wrapped = 1'b1;
      end

      n = ring_wrapped ? 64'(WINDOW_DEPTH) : 64'(ring_pos);
      if (n < 64'(MIN_GAPS)) return;

      s = gap_total;
      s2 = s * s;
      nq = n * gap_sq_total;
      spread = (nq >= s2) ? nq - s2 : 64'd0;

      if (s == 64'd0) begin
         if (thresholds.degraded_rate_hz != 0) rate = RATE_DISCONNECTED;
         else if (thresholds.nominal_rate_hz != 0) rate = RATE_DEGRADED;
         else rate = RATE_NOMINAL;
         below_excl = 1'b0;
         at_cont = 1'b1;
      end else begin
         if (64'(thresholds.degraded_rate_hz) * s > 64'(US_PER_S) * n)
            rate = RATE_DISCONNECTED;
         else if (64'(thresholds.nominal_rate_hz) * s > 64'(US_PER_S) * n)
            rate = RATE_DEGRADED;
         else
            rate = RATE_NOMINAL;
         spread_scaled = {32'd0, spread, 32'd0};
         excl_bound = 128'(thresholds.exclusive_cv_q16) * 128'(thresholds.exclusive_cv_q16)
                      * 128'(s2);
         cont_bound = 128'(thresholds.contested_cv_q16) * 128'(thresholds.contested_cv_q16)
                      * 128'(s2);
         below_excl = spread_scaled < excl_bound;
         at_cont = !(spread_scaled < cont_bound);
      end

      if (rate == RATE_NOMINAL) begin
         if (nominal_streak != 32'hFFFF_FFFF) nominal_streak++;
      end else begin
         nominal_streak = 32'd0;
      end

      if (rate == RATE_NOMINAL && below_excl) begin
         host = HOST_EXCLUSIVE;
      end else if (at_cont) begin
         host = HOST_CONTESTED;
         nominal_streak = 32'd0;
      end else begin
         host = HOST_UNKNOWN;
      end

      report.rate_state = rate;
      report.host_class = host;
      report.ready_res = (rate == RATE_NOMINAL) && (host != HOST_CONTESTED)
                         && (nominal_streak >= thresholds.warmup_needed);
      report.nominal_run = nominal_streak;
      report.window_count = n[5:0];
      report.interval_sum = s[25:0];
      report.spread_numerator = spread[51:0];
      report_queue.push_back(report);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         thresholds.degraded_rate_hz = DEGRADED_RATE_RESET;
         thresholds.nominal_rate_hz = NOMINAL_RATE_RESET;
         thresholds.exclusive_cv_q16 = EXCLUSIVE_CV_RESET;
         thresholds.contested_cv_q16 = CONTESTED_CV_RESET;
         thresholds.warmup_needed = WARMUP_RESET;
         last_stamp = 64'd0;
         ring_pos = 0;
         ring_wrapped = 1'b0;
         gap_total = 64'd0;
         gap_sq_total = 64'd0;
         nominal_streak = 32'd0;
         report_queue.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got_report = health_report_type'(rsp_tdata[REPORT_W-1:0]);
            if (report_queue.size() == 0) begin
               $error("Health report transaction arrived with none expected");
               bad_count++;
            end else begin
               want_report = report_queue.pop_front();
               bad_count += field_differs("rate_state", 64'(want_report.rate_state),
                                          64'(got_report.rate_state));
               bad_count += field_differs("host_class", 64'(want_report.host_class),
                                          64'(got_report.host_class));
               bad_count += field_differs("ready_res", 64'(want_report.ready_res),
                                          64'(got_report.ready_res));
               bad_count += field_differs("nominal_run", 64'(want_report.nominal_run),
                                          64'(got_report.nominal_run));
               bad_count += field_differs("window_count", 64'(want_report.window_count),
                                          64'(got_report.window_count));
               bad_count += field_differs("interval_sum", 64'(want_report.interval_sum),
                                          64'(got_report.interval_sum));
               bad_count += field_differs("spread_numerator",
                                          64'(want_report.spread_numerator),
                                          64'(got_report.spread_numerator));
               bad_count += field_differs("padding", 64'd0,
                                          64'(rsp_tdata[RSP_DATA_W-1:REPORT_W]));
               checked_count++;
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_DEGRADED_RATE: thresholds.degraded_rate_hz = csr_wdata[19:0];
               CSR_NOMINAL_RATE:  thresholds.nominal_rate_hz = csr_wdata[19:0];
               CSR_EXCLUSIVE_CV:  thresholds.exclusive_cv_q16 = csr_wdata[15:0];
               CSR_CONTESTED_CV:  thresholds.contested_cv_q16 = csr_wdata[15:0];
               CSR_WARMUP:        thresholds.warmup_needed = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) predict_health(req_tdata);
      end
      mismatch_count <= bad_count;
      reports_pending <= report_queue.size();
      reports_checked <= checked_count;
   end

endmodule

FILE: bench/sample_rate_health_monitor_unit_tb.sv
// Testbench top for the sample rate health monitor: stimulus, threshold settings and verdict.
module sample_rate_health_monitor_unit_tb;
   import srhm_pkg::*;

   localparam int WINDOW_DEPTH  = 60;
   localparam int PHASE_COUNT   = 8;
   localparam int RANDOM_STAMPS = 950;
   localparam int SETTLE_CYCLES = 30;
   localparam int CYCLE_LIMIT   = 1_200_000;
   localparam logic [CSR_IDX_W-1:0] CSR_FIRST_UNUSED = CSR_WARMUP + 3'd1;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int          mismatch_count;
   int          reports_pending;
   int          reports_checked;
   int          cycle_count = 0;
   int          stamps_sent = 0;
   bit          steady_sender = 1'b0;
   logic [63:0] now_us;
   logic [63:0] opening [$];

   sample_rate_health_monitor_unit #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   health_report_checker #(
      .WINDOW_DEPTH(WINDOW_DEPTH)
   ) report_check (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .mismatch_count  (mismatch_count),
      .reports_pending (reports_pending),
      .reports_checked (reports_checked)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin : receiver
      int open_len;
      int stall_len;
      int pick;
      @(posedge clock);
      forever begin
         pick = $urandom_range(0, 99);
         open_len = (pick < 15) ? $urandom_range(100, 400) : $urandom_range(1, 12);
         rsp_tready <= 1'b1;
         repeat (open_len) @(posedge clock);
         pick = $urandom_range(0, 99);
         if (pick < 80) stall_len = $urandom_range(1, 4);
         else if (pick < 96) stall_len = $urandom_range(5, 30);
         else stall_len = $urandom_range(40, 120);
         rsp_tready <= 1'b0;
         repeat (stall_len) @(posedge clock);
      end
   end

   task automatic send_stamp(input logic [63:0] stamp);
      int pause;
      int pick;
      pick = $urandom_range(0, 99);
      if (steady_sender || pick < 50) pause = 0;
      else if (pick < 85) pause = $urandom_range(1, 4);
      else if (pick < 97) pause = $urandom_range(5, 30);
      else pause = $urandom_range(40, 100);
      if (pause > 0) begin
         req_tvalid <= 1'b0;
         repeat (pause) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= stamp;
      do @(posedge clock); while (!req_tready);
      stamps_sent++;
   endtask

   task automatic drain_reports();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (reports_pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] index, input logic [31:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic apply_thresholds(input logic [19:0] degraded, input logic [19:0] nominal,
                                   input logic [15:0] exclusive, input logic [15:0] contested,
                                   input logic [31:0] warmup);
      write_reg(CSR_DEGRADED_RATE, 32'(degraded));
      write_reg(CSR_NOMINAL_RATE, 32'(nominal));
      write_reg(CSR_EXCLUSIVE_CV, 32'(exclusive));
      write_reg(CSR_CONTESTED_CV, 32'(contested));
      write_reg(CSR_WARMUP, warmup);
      for (int idx = CSR_FIRST_UNUSED; idx < 2 ** CSR_IDX_W; idx++)
         write_reg(CSR_IDX_W'(idx), $urandom);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input int stamps);
      int sent;
      int pick;
      int len;
      int base_us;
      int jitter_us;
      logic [63:0] gap_us;
      sent = 0;
      while (sent < stamps) begin
         pick = $urandom_range(0, 99);
         steady_sender = ($urandom_range(0, 4) == 0);
         len = $urandom_range(8, 80);
         if (pick < 45) begin
            base_us = $urandom_range(900, 1100);
            jitter_us = ($urandom_range(0, 3) == 0) ? base_us / 4
                        : $urandom_range(0, base_us / 40);
         end else if (pick < 65) begin
            base_us = $urandom_range(1000, 5000);
            jitter_us = $urandom_range(0, base_us / 2);
         end else if (pick < 80) begin
            base_us = $urandom_range(1, 3000);
            jitter_us = base_us;
         end else if (pick < 87) begin
            len = WINDOW_DEPTH + 4;
            base_us = 0;
            jitter_us = 0;
         end else if (pick < 94) begin
            len = $urandom_range(2, 6);
            base_us = 1 << 20;
            jitter_us = 1 << 19;
         end else begin
            len = $urandom_range(1, 4);
            base_us = -1;
            jitter_us = 0;
         end
         for (int k = 0; k < len && sent < stamps; k++) begin
            if (base_us < 0) begin
               now_us = ($urandom_range(0, 3) == 0) ? 64'd0 : {$urandom, $urandom};
            end else begin
               gap_us = 64'(base_us - jitter_us + int'($urandom_range(0, 2 * jitter_us)));
               now_us = now_us + gap_us;
            end
            send_stamp(now_us);
            sent++;
         end
      end
      steady_sender = 1'b0;
   endtask

   initial begin
      opening = '{64'd1000, 64'd1000, 64'd1000, 64'd1000, 64'd1000, 64'd1000,
                  64'd2000, 64'd3000, 64'd4000, 64'd0, 64'd5000, 64'd6000, 64'd3000,
                  64'd3000 + 64'h20_0000, 64'hFFFF_FFFF_FFFF_FC00,
                  64'hFFFF_FFFF_FFFF_FFFF, 64'd999, 64'd1999};
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (opening[i]) send_stamp(opening[i]);
      now_us = opening[opening.size() - 1];

      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         drain_reports();
         case (phase)
            0: apply_thresholds(20'd500, 20'd900, 16'd3277, 16'd19661, 32'd25);
            1: apply_thresholds(20'd0, 20'd0, 16'hFFFF, 16'd0, 32'd0);
            2: apply_thresholds(20'd1000000, 20'd1000000, 16'd0, 16'hFFFF, 32'hFFFF_FFFF);
            3: apply_thresholds(20'd800, 20'd990, 16'd6000, 16'd30000, 32'd3);
            default: apply_thresholds(20'($urandom_range(0, 1500)), 20'($urandom_range(0, 1500)),
                                      16'($urandom_range(0, 20000)),
                                      16'($urandom_range(0, 65535)),
                                      32'($urandom_range(0, 60)));
         endcase
         run_phase(RANDOM_STAMPS / PHASE_COUNT);
      end
      drain_reports();

      $display("Sent %0d timestamps across %0d threshold settings plus reset defaults.",
               stamps_sent, PHASE_COUNT);
      $display("Checked %0d health reports field by field.", reports_checked);
      if (mismatch_count == 0 && reports_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

FILE: files.f
hdl/srhm_pkg.sv
hdl/srhm_csr.sv
hdl/srhm_ctrl.sv
hdl/srhm_datapath.sv
hdl/sample_rate_health_monitor_unit.sv
bench/health_report_checker.sv
bench/sample_rate_health_monitor_unit_tb.sv
